// ----- src/assert_macros.svh -----
// Assertion helpers for the RTL file that carries checks, assembly_source_tokenizer.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define AST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define AST_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- src/ast_pkg.sv -----
`timescale 1ns / 1ps

package ast_pkg;

  // Width of the count fields on the result ports.
  localparam int unsigned TOK_W = 16;
  // Default width of the line, column and length counters.
  localparam int unsigned COUNT_BITS_DEF = 16;
  // Most results that one character can cause.
  localparam int unsigned RES_DEPTH = 2;

  // Character codes.
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_EQUAL    = 8'h3D;
  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_UNDER    = 8'h5F;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0  = 8'h30;
  localparam logic [7:0] CH_DIGIT_9  = 8'h39;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_IDENT   = 3'd1,
    MODE_NUMBER  = 3'd2,
    MODE_STRING  = 3'd3,
    MODE_COMMENT = 3'd4,
    MODE_DROP    = 3'd5
  } mode_e;

  typedef enum logic [3:0] {
    TOK_COMMA    = 4'd0,
    TOK_COLON    = 4'd1,
    TOK_ASSIGN   = 4'd2,
    TOK_LPAREN   = 4'd3,
    TOK_RPAREN   = 4'd4,
    TOK_LBRACE   = 4'd5,
    TOK_RBRACE   = 4'd6,
    TOK_LBRACKET = 4'd7,
    TOK_RBRACKET = 4'd8,
    TOK_IDENT    = 4'd9,
    TOK_NUMBER   = 4'd10,
    TOK_STRING   = 4'd11,
    TOK_NEWLINE  = 4'd12,
    TOK_ERROR    = 4'd13
  } tok_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_UNTERM  = 2'd1,
    ERR_UNEXPEC = 2'd2
  } err_e;

  // One result item.
  typedef struct packed {
    tok_kind_e        kind;
    logic [TOK_W-1:0] len;
    logic [TOK_W-1:0] line;
    logic [TOK_W-1:0] col;
    err_e             err;
    logic             run_end;
  } res_t;

endpackage

// ----- src/ast_step.sv -----
`timescale 1ns / 1ps

module ast_step import ast_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  mode_e                 mode_i,
  input  logic [COUNT_BITS-1:0] line_i,
  input  logic [COUNT_BITS-1:0] col_i,
  input  logic [COUNT_BITS-1:0] len_i,
  input  logic [7:0]            ch_i,
  input  logic                  fin_i,
  output mode_e                 mode_o,
  output logic [COUNT_BITS-1:0] line_o,
  output logic [COUNT_BITS-1:0] col_o,
  output logic [COUNT_BITS-1:0] len_o,
  output res_t [1:0]            res_o,
  output logic [1:0]            nres_o
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_ONE;
  endfunction

  // Fit a counter to the port width: zero-extend or keep the low bits.
  function automatic logic [TOK_W-1:0] fit(logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS+TOK_W-1:0] w;
    w = {{TOK_W{1'b0}}, v};
    return w[TOK_W-1:0];
  endfunction

  function automatic res_t mk_res(tok_kind_e k, logic [COUNT_BITS-1:0] ln, err_e e,
                                  logic [COUNT_BITS-1:0] li, logic [COUNT_BITS-1:0] cl);
    res_t r;
    r.kind    = k;
    r.len     = fit(ln);
    r.line    = fit(li);
    r.col     = fit(cl);
    r.err     = e;
    r.run_end = 1'b0;
    return r;
  endfunction

  // Character classes.
  logic      is_alpha, is_digit, is_ident, is_punct;
  tok_kind_e punct_kind;

  assign is_alpha = ((ch_i >= CH_UPPER_A) && (ch_i <= CH_UPPER_Z)) ||
                    ((ch_i >= CH_LOWER_A) && (ch_i <= CH_LOWER_Z));
  assign is_digit = (ch_i >= CH_DIGIT_0) && (ch_i <= CH_DIGIT_9);
  assign is_ident = is_alpha || is_digit || (ch_i == CH_UNDER);

  always_comb begin
    is_punct   = 1'b1;
    punct_kind = TOK_COMMA;
    case (ch_i)
      CH_COMMA:    punct_kind = TOK_COMMA;
      CH_COLON:    punct_kind = TOK_COLON;
      CH_EQUAL:    punct_kind = TOK_ASSIGN;
      CH_LPAREN:   punct_kind = TOK_LPAREN;
      CH_RPAREN:   punct_kind = TOK_RPAREN;
      CH_LBRACE:   punct_kind = TOK_LBRACE;
      CH_RBRACE:   punct_kind = TOK_RBRACE;
      CH_LBRACKET: punct_kind = TOK_LBRACKET;
      CH_RBRACKET: punct_kind = TOK_RBRACKET;
      default:     is_punct   = 1'b0;
    endcase
  end

  // One scan step: results are filled in order, slot n[0] next.
  mode_e                 m;
  logic [COUNT_BITS-1:0] l, co, tl;
  logic [1:0]            n;
  logic                  failed, do_idle, more;
  tok_kind_e             run_kind;
  res_t [1:0]            r;

  always_comb begin
    m        = mode_i;
    l        = line_i;
    co       = col_i;
    tl       = len_i;
    n        = 2'd0;
    failed   = 1'b0;
    do_idle  = 1'b0;
    r        = '0;
    more     = (mode_i == MODE_IDENT) ? is_ident : is_digit;
    run_kind = (mode_i == MODE_IDENT) ? TOK_IDENT : TOK_NUMBER;

    case (mode_i)
      MODE_DROP: begin
        m = MODE_DROP;
      end
      MODE_IDENT, MODE_NUMBER: begin
        if (more) begin
          tl = sat_inc(tl);
          if (!fin_i) co = sat_inc(co);
          if (fin_i) begin
            r[n[0]] = mk_res(run_kind, tl, ERR_NONE, l, co);
            n       = n + 2'd1;
          end
        end else begin
          // The run ends here; the character is scanned again from idle.
          r[n[0]] = mk_res(run_kind, tl, ERR_NONE, l, co);
          n       = n + 2'd1;
          m       = MODE_IDLE;
          do_idle = 1'b1;
        end
      end
      MODE_STRING: begin
        if (ch_i == CH_QUOTE) begin
          r[n[0]] = mk_res(TOK_STRING, tl, ERR_NONE, l, co);
          n       = n + 2'd1;
          if (!fin_i) co = sat_inc(co);
          m = MODE_IDLE;
        end else begin
          tl = sat_inc(tl);
          if (!fin_i) co = sat_inc(co);
          if (fin_i) begin
            r[n[0]] = mk_res(TOK_ERROR, '0, ERR_UNTERM, l, co);
            n       = n + 2'd1;
            failed  = 1'b1;
          end
        end
      end
      MODE_COMMENT: begin
        if (ch_i != CH_NL) begin
          if (!fin_i) co = sat_inc(co);
        end else begin
          m       = MODE_IDLE;
          do_idle = 1'b1;
        end
      end
      default: begin
        m       = MODE_IDLE;
        do_idle = 1'b1;
      end
    endcase

    // Start of a new token or a separator.
    if (do_idle) begin
      if (is_punct) begin
        if (!fin_i) co = sat_inc(co);
        r[n[0]] = mk_res(punct_kind, CNT_ONE, ERR_NONE, l, co);
        n       = n + 2'd1;
      end else if (ch_i == CH_QUOTE) begin
        if (!fin_i) co = sat_inc(co);
        tl = '0;
        m  = MODE_STRING;
        if (fin_i) begin
          r[n[0]] = mk_res(TOK_ERROR, '0, ERR_UNTERM, l, co);
          n       = n + 2'd1;
          failed  = 1'b1;
        end
      end else if (ch_i == CH_SEMI) begin
        m = MODE_COMMENT;
        if (!fin_i) co = sat_inc(co);
      end else if ((ch_i == CH_SPACE) || (ch_i == CH_TAB)) begin
        if (!fin_i) co = sat_inc(co);
      end else if (ch_i == CH_NL) begin
        if (!fin_i) co = sat_inc(co);
        r[n[0]] = mk_res(TOK_NEWLINE, CNT_ONE, ERR_NONE, l, co);
        n       = n + 2'd1;
        l       = sat_inc(l);
        co      = CNT_ONE;
      end else if (is_alpha || is_digit) begin
        m  = is_alpha ? MODE_IDENT : MODE_NUMBER;
        tl = CNT_ONE;
        if (!fin_i) co = sat_inc(co);
        if (fin_i) begin
          r[n[0]] = mk_res(is_alpha ? TOK_IDENT : TOK_NUMBER, tl, ERR_NONE, l, co);
          n       = n + 2'd1;
        end
      end else begin
        r[n[0]] = mk_res(TOK_ERROR, '0, ERR_UNEXPEC, l, co);
        n       = n + 2'd1;
        failed  = 1'b1;
      end
    end

    // The end of the text restores the reset state; an error starts dropping.
    if (fin_i) begin
      m  = MODE_IDLE;
      l  = CNT_ONE;
      co = CNT_ONE;
      tl = '0;
    end else if (failed) begin
      m = MODE_DROP;
    end

    r[0].run_end = (n == 2'd1);
    r[1].run_end = (n == 2'd2);
  end

  assign mode_o = m;
  assign line_o = l;
  assign col_o  = co;
  assign len_o  = tl;
  assign res_o  = r;
  assign nres_o = n;

endmodule

// ----- src/ast_res_fifo.sv -----
`timescale 1ns / 1ps

module ast_res_fifo import ast_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] wr_cnt_i,
  input  res_t [1:0] wr_data_i,
  output logic       rd_valid_o,
  input  logic       rd_ready_i,
  output res_t       rd_data_o,
  output logic [1:0] free_o
);

  res_t       mem_q [RES_DEPTH];
  logic [1:0] count_q, count_d;
  logic       head_q, head_d;
  logic       pop, tail;

  assign rd_valid_o = (count_q != 2'd0);
  assign rd_data_o  = mem_q[head_q];
  assign pop        = rd_valid_o && rd_ready_i;

  // Slots open to a write in this cycle, the one read out now included.
  assign free_o  = 2'd2 - count_q + {1'b0, pop};
  assign count_d = count_q - {1'b0, pop} + wr_cnt_i;
  assign head_d  = head_q ^ pop;
  assign tail    = head_q ^ count_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      head_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      head_q  <= head_d;
    end
  end

  // Result storage, written in order at the tail.
  always_ff @(posedge clk_i) begin
    if (wr_cnt_i != 2'd0) begin
      mem_q[tail] <= wr_data_i[0];
    end
    if (wr_cnt_i == 2'd2) begin
      mem_q[~tail] <= wr_data_i[1];
    end
  end

endmodule

// ----- src/assembly_source_tokenizer.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Character-stream tokenizer for assembly source. One character is taken per
// clock cycle into an input register, unless the input register is held while
// its character's results do not fit the two-entry result buffer. The scan
// step between that register and the result buffer is combinational, so a
// character's results are registered into the result buffer when it leaves
// the input register. A character that ends an identifier or number and also
// gives a punctuation, newline or error token yields two results; the input
// then waits until the result buffer has two free slots. The rate is set by
// the result buffer's single read port. Results carry run_end on the last
// token that a character causes. After the final character the line and
// column counters return to 1 and the length counter returns to 0.
module assembly_source_tokenizer import ast_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       ch_i,
  input  logic             final_char_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [3:0]       tok_kind_o,
  output logic [TOK_W-1:0] tok_len_o,
  output logic [TOK_W-1:0] tok_line_o,
  output logic [TOK_W-1:0] tok_col_o,
  output logic [1:0]       err_code_o,
  output logic             run_end_o
);

  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  // Input register.
  logic       in_vld_q;
  logic [7:0] ch_q;
  logic       fin_q;
  logic       fire;

  // Scan state.
  mode_e                 mode_q, mode_d;
  logic [COUNT_BITS-1:0] line_q, line_d, col_q, col_d, len_q, len_d;

  res_t [1:0] step_res;
  logic [1:0] nres, free;
  res_t       head;
  logic       at_start;

  assign fire       = in_vld_q && (nres <= free);
  assign in_ready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ch_q  <= ch_i;
      fin_q <= final_char_i;
    end
  end

  ast_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .mode_i (mode_q),
    .line_i (line_q),
    .col_i  (col_q),
    .len_i  (len_q),
    .ch_i   (ch_q),
    .fin_i  (fin_q),
    .mode_o (mode_d),
    .line_o (line_d),
    .col_o  (col_d),
    .len_o  (len_d),
    .res_o  (step_res),
    .nres_o (nres)
  );

  // Scan state advances only when the character's results fit the buffer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      line_q <= CNT_ONE;
      col_q  <= CNT_ONE;
      len_q  <= '0;
    end else if (fire) begin
      mode_q <= mode_d;
      line_q <= line_d;
      col_q  <= col_d;
      len_q  <= len_d;
    end
  end

  ast_res_fifo u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_cnt_i   (fire ? nres : 2'd0),
    .wr_data_i  (step_res),
    .rd_valid_o (out_valid_o),
    .rd_ready_i (out_ready_i),
    .rd_data_o  (head),
    .free_o     (free)
  );

  assign tok_kind_o = head.kind;
  assign tok_len_o  = head.len;
  assign tok_line_o = head.line;
  assign tok_col_o  = head.col;
  assign err_code_o = head.err;
  assign run_end_o  = head.run_end;

  // Checks on the scan state.
  assign at_start = (mode_q == MODE_IDLE) && (line_q == CNT_ONE) && (col_q == CNT_ONE);

  `AST_ASSERT(a_line_col_nonzero, (line_q != '0) && (col_q != '0), "line or column is zero")
  `AST_ASSERT(a_final_restarts, fire && fin_q |=> at_start, "final character left state set")
  `AST_ASSERT(a_drop_is_silent, fire && (mode_q == MODE_DROP) |-> (nres == 2'd0), "drop gave a token")

endmodule
